// ===== src/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types, constants and ring helpers for the ring byte FIFO with peek.
// ----------------------------------------------------------------------------
package rbf_pkg;

  // ring store size, at most DEPTH-1 entries in use
  localparam int DEPTH = 256;
  localparam int PTR_W = $clog2(DEPTH);
  // compare width: wide enough for a ring index, a length or an 8-bit request, plus one bit
  localparam int CMP_W = ((PTR_W > 8) ? PTR_W : 8) + 1;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_DISCARD = 2'd1,
    OP_PEEK    = 2'd2,
    OP_FLUSH   = 2'd3
  } op_t;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] byte_in;
    logic [7:0] count;
    logic [7:0] offset;
  } in_item_t;

  typedef struct packed {
    logic [7:0] done_count;
    logic [7:0] peek_data;
    logic       peek_ok;
    logic [7:0] fill_level;
    logic       is_full;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic capture;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_peek;
  } dp_status_t;

  // advance a ring index by n, n below DEPTH
  function automatic ptr_t ring_add(input ptr_t a, input ptr_t n);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, n};
    if (s >= (PTR_W+1)'(DEPTH)) begin
      s = s - (PTR_W+1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  // number of stored bytes between head and tail
  function automatic ptr_t ring_len(input ptr_t head, input ptr_t tail);
    logic [PTR_W:0] l;
    if (tail >= head) begin
      l = {1'b0, tail} - {1'b0, head};
    end else begin
      l = {1'b0, tail} + (PTR_W+1)'(DEPTH) - {1'b0, head};
    end
    return l[PTR_W-1:0];
  endfunction

endpackage

// ===== src/rbf_ram.sv =====
// ----------------------------------------------------------------------------
// rbf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbf_ctrl
// Sequencer: takes one transaction, waits in S_READ for peek read data, then
// presents the result until it is taken.
// ----------------------------------------------------------------------------
module rbf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  rbf_pkg::dp_status_t    status,
  output rbf_pkg::ctrl_cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_HOLD
  } state_t;

  state_t state;

  // commands to the datapath
  assign cmd.accept  = in_valid & ~in_stall;
  assign cmd.capture = (state == S_READ);

  // state and handshake registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_stall <= 1'b1;
            if (status.in_is_peek) begin
              state <= S_READ;
            end else begin
              state     <= S_HOLD;
              out_valid <= 1'b1;
            end
          end
        end
        S_READ: begin
          state     <= S_HOLD;
          out_valid <= 1'b1;
        end
        S_HOLD: begin
          if (!out_stall) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
            in_stall  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/rbf_dp.sv =====
// ----------------------------------------------------------------------------
// rbf_dp
// Datapath: head and tail pointers, byte store and the result register.
// ----------------------------------------------------------------------------
module rbf_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  rbf_pkg::in_item_t    in_data,
  input  rbf_pkg::ctrl_cmd_t   cmd,
  output rbf_pkg::dp_status_t  status,
  output rbf_pkg::out_item_t   out_data
);

  rbf_pkg::ptr_t head;
  rbf_pkg::ptr_t tail;
  rbf_pkg::ptr_t head_next;
  rbf_pkg::ptr_t tail_next;
  rbf_pkg::ptr_t len;
  rbf_pkg::ptr_t len_after;
  rbf_pkg::ptr_t clamp_cnt;
  rbf_pkg::ptr_t rd_addr;
  logic [rbf_pkg::CMP_W-1:0] len_ext;
  logic [rbf_pkg::CMP_W-1:0] cnt_ext;
  logic [rbf_pkg::CMP_W-1:0] off_ext;
  logic       full;
  logic       wr_en;
  logic       rd_en;
  logic       peek_hit;
  logic [7:0] done;
  logic [7:0] rd_data;

  assign status.in_is_peek = (in_data.opcode == rbf_pkg::OP_PEEK);

  // current length and request compares
  always_comb begin
    len       = rbf_pkg::ring_len(head, tail);
    full      = (len == rbf_pkg::PTR_W'(rbf_pkg::DEPTH - 1));
    len_ext   = rbf_pkg::CMP_W'(len);
    cnt_ext   = rbf_pkg::CMP_W'(in_data.count);
    off_ext   = rbf_pkg::CMP_W'(in_data.offset);
    clamp_cnt = (cnt_ext > len_ext) ? len : rbf_pkg::PTR_W'(cnt_ext);
    peek_hit  = (off_ext < len_ext);
    rd_addr   = rbf_pkg::ring_add(head, rbf_pkg::PTR_W'(off_ext));
  end

  // operation decode and next pointers
  always_comb begin
    head_next = head;
    tail_next = tail;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    done      = 8'd0;
    unique case (in_data.opcode)
      rbf_pkg::OP_PUSH: begin
        if (!full) begin
          wr_en     = cmd.accept;
          tail_next = rbf_pkg::ring_add(tail, rbf_pkg::PTR_W'(1));
          done      = 8'd1;
        end
      end
      rbf_pkg::OP_DISCARD: begin
        head_next = rbf_pkg::ring_add(head, clamp_cnt);
        done      = 8'(clamp_cnt);
      end
      rbf_pkg::OP_PEEK: begin
        rd_en = cmd.accept & peek_hit;
      end
      rbf_pkg::OP_FLUSH: begin
        head_next = tail;
      end
    endcase
    len_after = rbf_pkg::ring_len(head_next, tail_next);
  end

  // byte store
  rbf_ram #(
    .WIDTH (8),
    .DEPTH (rbf_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail),
    .wdata (in_data.byte_in),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (cmd.accept) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  // result register; peek data is captured in S_READ, the cycle after the other fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_data.done_count <= done;
      out_data.peek_data  <= 8'd0;
      out_data.peek_ok    <= status.in_is_peek & peek_hit;
      out_data.fill_level <= 8'(len_after);
      out_data.is_full    <= (len_after == rbf_pkg::PTR_W'(rbf_pkg::DEPTH - 1));
    end else if (cmd.capture && out_data.peek_ok) begin
      out_data.peek_data <= rd_data;
    end
  end

endmodule

// ===== src/ring_byte_fifo_indexed_peek_top.sv =====
// ----------------------------------------------------------------------------
// ring_byte_fifo_indexed_peek_top
// Byte FIFO in a ring store with push, discard, indexed peek and flush.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload             | handshake
//   --------+-----------+---------------------+-------------------------
//   in      | input     | rbf_pkg::in_item_t  | in_valid  / in_stall
//   out     | output    | rbf_pkg::out_item_t | out_valid / out_stall
//
// One transaction at a time. Push, discard and flush present their result in the
// cycle after acceptance; peek passes through S_READ first for the registered store
// read. The next transaction is taken the cycle after the result is taken.
// Synchronous reset empties the FIFO; store contents are left as they are.
// Output stall holds the result and keeps in_stall high.
//
module ring_byte_fifo_indexed_peek_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rbf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rbf_pkg::out_item_t out_data
);

  rbf_pkg::ctrl_cmd_t  cmd;
  rbf_pkg::dp_status_t status;

  // sequencer
  rbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // pointers, store and result
  rbf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== bench/ring_fifo_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_fifo_monitor
// Watches both channels of the ring byte FIFO, keeps a shadow FIFO that is
// updated on every accepted input transaction, and compares each accepted
// result with the oldest predicted one. Reports the number of mismatches and
// the number of results still due.
// ----------------------------------------------------------------------------
module ring_fifo_monitor (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rbf_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rbf_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 replies_due
);

  // shadow copy of the ring store and its pointers
  logic [7:0] shadow_mem [rbf_pkg::DEPTH];
  int         rd_ptr;
  int         wr_ptr;
  int         err_total = 0;

  // results predicted but not yet seen on the output channel
  rbf_pkg::out_item_t fifo_replies_due [$];

  assign mismatches  = err_total;
  assign replies_due = fifo_replies_due.size();

  initial begin
    foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
    rd_ptr = 0;
    wr_ptr = 0;
  end

  // ring index advance, n below DEPTH
  function automatic int step_ptr(input int p, input int n);
    int s;
    s = p + n;
    if (s >= rbf_pkg::DEPTH) s = s - rbf_pkg::DEPTH;
    return s;
  endfunction

  function automatic int fill_of(input int head, input int tail);
    if (tail >= head) return tail - head;
    return tail + rbf_pkg::DEPTH - head;
  endfunction

  // apply one operation to the shadow FIFO and build its result
  function automatic rbf_pkg::out_item_t apply_fifo_op(input rbf_pkg::in_item_t op_in);
    rbf_pkg::out_item_t r;
    int                 len;
    int                 n;
    r   = '0;
    len = fill_of(rd_ptr, wr_ptr);
    case (op_in.opcode)
      rbf_pkg::OP_PUSH: begin
        if (len != rbf_pkg::DEPTH - 1) begin
          shadow_mem[wr_ptr] = op_in.byte_in;
          wr_ptr             = step_ptr(wr_ptr, 1);
          r.done_count       = 8'd1;
        end
      end
      rbf_pkg::OP_DISCARD: begin
        n            = int'(op_in.count);
        if (n > len) n = len;
        rd_ptr       = step_ptr(rd_ptr, n);
        r.done_count = n[7:0];
      end
      rbf_pkg::OP_PEEK: begin
        if (int'(op_in.offset) < len) begin
          r.peek_data = shadow_mem[step_ptr(rd_ptr, int'(op_in.offset))];
          r.peek_ok   = 1'b1;
        end
      end
      rbf_pkg::OP_FLUSH: begin
        rd_ptr = wr_ptr;
      end
      default: ;
    endcase
    len          = fill_of(rd_ptr, wr_ptr);
    r.fill_level = len[7:0];
    r.is_full    = (len == rbf_pkg::DEPTH - 1);
    return r;
  endfunction

  // output side is checked before the input side is predicted
  always @(posedge clk) begin
    rbf_pkg::out_item_t want;
    if (rst) begin
      rd_ptr = 0;
      wr_ptr = 0;
      fifo_replies_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (fifo_replies_due.size() == 0) begin
          if (err_total < 10)
            $display("[%0t] result with nothing due: done=%h data=%h ok=%b fill=%h full=%b",
                     $realtime, out_data.done_count, out_data.peek_data,
                     out_data.peek_ok, out_data.fill_level, out_data.is_full);
          err_total++;
        end else begin
          want = fifo_replies_due.pop_front();
          if (out_data.done_count !== want.done_count ||
              out_data.peek_data  !== want.peek_data  ||
              out_data.peek_ok    !== want.peek_ok    ||
              out_data.fill_level !== want.fill_level ||
              out_data.is_full    !== want.is_full) begin
            if (err_total < 10)
              $display({"[%0t] mismatch exp done=%h data=%h ok=%b fill=%h full=%b",
                        " | got done=%h data=%h ok=%b fill=%h full=%b"},
                       $realtime, want.done_count, want.peek_data, want.peek_ok,
                       want.fill_level, want.is_full, out_data.done_count,
                       out_data.peek_data, out_data.peek_ok, out_data.fill_level,
                       out_data.is_full);
            err_total++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        fifo_replies_due.push_back(apply_fifo_op(in_data));
      end
    end
  end

endmodule

// ===== bench/tb_ring_byte_fifo_indexed_peek_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ring_byte_fifo_indexed_peek_top
// Drives push, discard, peek and flush transactions into the ring byte FIFO:
// a short directed sequence, then random phases that fill, drain, mix and
// scramble the FIFO, with random idle bursts on both channels. The monitor
// predicts and checks every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_ring_byte_fifo_indexed_peek_top;

  localparam int RAND_ITEMS = 1700;
  localparam int QUIET_TAIL = 200;

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED,
    PH_NOISE
  } phase_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  rbf_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rbf_pkg::out_item_t out_data;

  int        mismatches;
  int        replies_due;
  bit        quiet     = 1'b0;
  bit        gaps_on   = 1'b1;

  ring_byte_fifo_indexed_peek_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ring_fifo_monitor mon (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .replies_due (replies_due)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // build one transaction; a field given as a negative value gets random bits
  function automatic rbf_pkg::in_item_t make_item(input rbf_pkg::op_t op, input int b,
                                                  input int c, input int o);
    rbf_pkg::in_item_t it;
    it.opcode  = op;
    it.byte_in = (b < 0) ? 8'($urandom) : 8'(b);
    it.count   = (c < 0) ? 8'($urandom) : 8'(c);
    it.offset  = (o < 0) ? 8'($urandom) : 8'(o);
    return it;
  endfunction

  // peek offsets lean toward the head and toward the top of a full FIFO
  function automatic int pick_offset();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom_range(0, 15);
      2:       return $urandom_range(240, 255);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic rbf_pkg::in_item_t pick_item(input phase_t ph);
    int sel;
    sel = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (sel < 85)      return make_item(rbf_pkg::OP_PUSH, -1, -1, -1);
        else if (sel < 95) return make_item(rbf_pkg::OP_PEEK, -1, -1, pick_offset());
        else               return make_item(rbf_pkg::OP_DISCARD, -1,
                                            $urandom_range(0, 3), -1);
      end
      PH_DRAIN: begin
        if (sel < 40)      return make_item(rbf_pkg::OP_DISCARD, -1,
                                            $urandom_range(0, 6), -1);
        else if (sel < 80) return make_item(rbf_pkg::OP_PEEK, -1, -1, pick_offset());
        else if (sel < 96) return make_item(rbf_pkg::OP_PUSH, -1, -1, -1);
        else               return make_item(rbf_pkg::OP_FLUSH, -1, -1, -1);
      end
      PH_MIXED: begin
        if (sel < 35)      return make_item(rbf_pkg::OP_PUSH, -1, -1, -1);
        else if (sel < 60) begin
          if ($urandom_range(0, 3) == 0) return make_item(rbf_pkg::OP_DISCARD, -1, -1, -1);
          return make_item(rbf_pkg::OP_DISCARD, -1, $urandom_range(0, 20), -1);
        end
        else if (sel < 95) return make_item(rbf_pkg::OP_PEEK, -1, -1, pick_offset());
        else               return make_item(rbf_pkg::OP_FLUSH, -1, -1, -1);
      end
      default: return make_item(rbf_pkg::op_t'($urandom_range(0, 3)), -1, -1, -1);
    endcase
  endfunction

  // hold the transaction until accepted, then maybe idle for a while
  task automatic issue_op(input rbf_pkg::in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // output stall: random bursts with calm stretches in between
  initial begin : rx_stall_gen
    int burst_left;
    int calm_left;
    burst_left = 0;
    calm_left  = 0;
    forever begin
      @(posedge clk);
      if (quiet || rst) begin
        out_stall <= 1'b0;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (calm_left > 0) begin
        out_stall <= 1'b0;
        calm_left--;
      end else begin
        case ($urandom_range(0, 15))
          0, 1: begin
            out_stall  <= 1'b1;
            burst_left = $urandom_range(0, 17);
          end
          2: begin
            out_stall <= 1'b0;
            calm_left = $urandom_range(40, 200);
          end
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    phase_t ph;
    int     left_in_phase;
    int     sel;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty FIFO corner cases
    issue_op(make_item(rbf_pkg::OP_PEEK, -1, -1, 0));
    issue_op(make_item(rbf_pkg::OP_DISCARD, -1, 5, -1));
    issue_op(make_item(rbf_pkg::OP_FLUSH, -1, -1, -1));
    // directed: byte extremes and peeks in and out of range
    issue_op(make_item(rbf_pkg::OP_PUSH, 8'h00, -1, -1));
    issue_op(make_item(rbf_pkg::OP_PUSH, 8'hff, -1, -1));
    issue_op(make_item(rbf_pkg::OP_PUSH, 8'ha5, -1, -1));
    issue_op(make_item(rbf_pkg::OP_PEEK, -1, -1, 0));
    issue_op(make_item(rbf_pkg::OP_PEEK, -1, -1, 2));
    issue_op(make_item(rbf_pkg::OP_PEEK, -1, -1, 3));
    issue_op(make_item(rbf_pkg::OP_PEEK, -1, -1, 255));
    // directed: zero discard, single discard, discard past the length
    issue_op(make_item(rbf_pkg::OP_DISCARD, -1, 0, -1));
    issue_op(make_item(rbf_pkg::OP_DISCARD, -1, 1, -1));
    issue_op(make_item(rbf_pkg::OP_PEEK, -1, -1, 0));
    issue_op(make_item(rbf_pkg::OP_DISCARD, -1, 255, -1));
    // directed: flush a nonempty FIFO
    issue_op(make_item(rbf_pkg::OP_PUSH, 8'h5a, -1, -1));
    issue_op(make_item(rbf_pkg::OP_PUSH, 8'h3c, -1, -1));
    issue_op(make_item(rbf_pkg::OP_FLUSH, -1, -1, -1));
    issue_op(make_item(rbf_pkg::OP_PEEK, -1, -1, 0));
    issue_op(make_item(rbf_pkg::OP_PUSH, 8'h81, -1, -1));
    issue_op(make_item(rbf_pkg::OP_PEEK, -1, -1, 0));
    issue_op(make_item(rbf_pkg::OP_DISCARD, -1, 1, -1));

    // random phases; the first one fills past full
    ph            = PH_FILL;
    left_in_phase = 320;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (left_in_phase == 0) begin
        sel = $urandom_range(0, 9);
        if (sel < 3)      ph = PH_FILL;
        else if (sel < 6) ph = PH_DRAIN;
        else if (sel < 9) ph = PH_MIXED;
        else              ph = PH_NOISE;
        left_in_phase = (ph == PH_FILL) ? $urandom_range(100, 300) : $urandom_range(20, 120);
        gaps_on       = ($urandom_range(0, 3) != 0);
      end
      if (n >= RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
      issue_op(pick_item(ph));
      left_in_phase--;
    end
    in_valid <= 1'b0;

    // drain the remaining results, then let the pipeline settle
    while (replies_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && replies_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
